// ----- rtl/bpa_pkg.sv -----
// package: types, constants and address helpers for the buddy page allocator
package bpa_pkg;

  localparam int PAGE_BITS = 16;
  localparam int LEVELS    = 11;
  localparam int LVL_W     = 4;
  localparam int CUR_W     = LVL_W + 1;
  localparam int CNT_W     = PAGE_BITS + 1;
  localparam int SADDR_W   = PAGE_BITS + 1;
  localparam int PADDR_W   = PAGE_BITS;
  localparam int STACK_DEPTH = 2 ** SADDR_W;
  localparam int PAIR_DEPTH  = 2 ** PADDR_W;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_OOM           = 2'd1,
    ST_BAD_LEVEL     = 2'd2,
    ST_BUDDY_MISSING = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic             cmd;
    logic [LVL_W-1:0] level;
    page_t            page;
  } in_item_t;

  typedef struct packed {
    page_t      alloc_page;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH,
    S_A_SEARCH, S_A_RDTOP, S_A_RDPAIR, S_A_TOGGLE, S_A_PUSHLO, S_A_PUSHHI,
    S_F_CHECK, S_F_RDPAIR, S_F_DECIDE, S_F_KINIT, S_F_RDK, S_F_CMP,
    S_F_MOVE, S_F_WRMOVE, S_F_MERGE, S_F_PUSH, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_NEXT_LV, OP_RD_TOP, OP_RD_PAIR_TOP, OP_TOGGLE,
    OP_PUSH_LO, OP_PUSH_HI, OP_RD_PAIR, OP_K_INIT, OP_RD_K, OP_RD_NEXT,
    OP_WR_MOVE, OP_MERGE, OP_PUSH_SET
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    emit;
    status_e res_status;
    logic    res_page;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cur_ge;
    logic cur_top;
    logic cnt_zero;
    logic at_req;
    logic pair_bit;
    logic k_zero;
    logic match;
    logic move_more;
    logic out_free;
    logic clr_last;
    logic req_bad;
  } dp_stat_t;

  function automatic logic [SADDR_W-1:0] stack_base(input logic [LVL_W-1:0] lv);
    logic [SADDR_W:0] span;
    span = ((SADDR_W+1)'(1) << (SADDR_W - int'(lv))) - (SADDR_W+1)'(1);
    return ~span[SADDR_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] stack_cap(input logic [LVL_W-1:0] lv);
    return CNT_W'(1) << (PAGE_BITS - int'(lv));
  endfunction

  function automatic logic [PADDR_W-1:0] pair_idx(input logic [LVL_W-1:0] lv,
                                                  input page_t pg);
    logic [PADDR_W:0] span;
    logic [PADDR_W-1:0] base;
    span = ((PADDR_W+1)'(1) << (PADDR_W - int'(lv))) - (PADDR_W+1)'(1);
    base = ~span[PADDR_W-1:0];
    return base + PADDR_W'(pg >> (int'(lv) + 1));
  endfunction

  function automatic page_t align(input page_t pg, input logic [LVL_W-1:0] lv);
    return (pg >> lv) << lv;
  endfunction

endpackage

// ----- rtl/buddy_page_allocator_unit.sv -----
// top level: buddy page allocator with controller and datapath
// allocate: search upward for a level with a free block (out of memory past the top level),
// then split level by level down to the requested level; free: merge upward while the buddy
// is free, else push; the stack walk of the buddy search sets the cost of a free
// throughput: one beat at a time; a new beat is taken while the previous result waits
// reset: asynchronous active low; stacks empty, then a pass that clears every pair bitmap entry
module buddy_page_allocator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bpa_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpa_pkg::out_item_t out_data_o
);

  bpa_pkg::ctrl_cmd_t cmd;
  bpa_pkg::dp_stat_t  stat;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- rtl/bpa_ctrl.sv -----
// controller: sequences allocate and free operations over the datapath
module bpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_cmd_i,
  output logic                 in_stall_o,
  input  bpa_pkg::dp_stat_t    stat_i,
  output bpa_pkg::ctrl_cmd_t   cmd_o
);

  bpa_pkg::state_e  state_q, state_d;
  bpa_pkg::status_e res_q, res_d;
  logic             rpage_q, rpage_d;
  logic             free_q, free_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpa_pkg::S_CLEAR;
      res_q   <= bpa_pkg::ST_OK;
      rpage_q <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
      rpage_q <= rpage_d;
      free_q  <= free_d;
    end
  end

  assign in_stall_o = (state_q != bpa_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    rpage_d = rpage_q;
    free_d  = free_q;
    cmd_o.op         = bpa_pkg::OP_NONE;
    cmd_o.emit       = 1'b0;
    cmd_o.res_status = res_q;
    cmd_o.res_page   = rpage_q;
    unique case (state_q)
      bpa_pkg::S_CLEAR: begin
        cmd_o.op = bpa_pkg::OP_CLEAR;
        if (stat_i.clr_last) state_d = bpa_pkg::S_IDLE;
      end
      bpa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = bpa_pkg::OP_LOAD;
          free_d   = (in_cmd_i == bpa_pkg::CMD_FREE);
          state_d  = bpa_pkg::S_DISPATCH;
        end
      end
      bpa_pkg::S_DISPATCH: begin
        rpage_d = 1'b0;
        res_d   = bpa_pkg::ST_OK;
        if (!free_q) state_d = bpa_pkg::S_A_SEARCH;
        else if (stat_i.req_bad) begin
          res_d   = bpa_pkg::ST_BAD_LEVEL;
          state_d = bpa_pkg::S_DONE;
        end else state_d = bpa_pkg::S_F_CHECK;
      end
      bpa_pkg::S_A_SEARCH: begin
        if (stat_i.cur_ge) begin
          res_d   = bpa_pkg::ST_OOM;
          state_d = bpa_pkg::S_DONE;
        end else if (stat_i.cnt_zero) cmd_o.op = bpa_pkg::OP_NEXT_LV;
        else state_d = bpa_pkg::S_A_RDTOP;
      end
      bpa_pkg::S_A_RDTOP: begin
        cmd_o.op = bpa_pkg::OP_RD_TOP;
        state_d  = bpa_pkg::S_A_RDPAIR;
      end
      bpa_pkg::S_A_RDPAIR: begin
        cmd_o.op = bpa_pkg::OP_RD_PAIR_TOP;
        state_d  = bpa_pkg::S_A_TOGGLE;
      end
      bpa_pkg::S_A_TOGGLE: begin
        cmd_o.op = bpa_pkg::OP_TOGGLE;
        if (stat_i.at_req) begin
          rpage_d = 1'b1;
          state_d = bpa_pkg::S_DONE;
        end else state_d = bpa_pkg::S_A_PUSHLO;
      end
      bpa_pkg::S_A_PUSHLO: begin
        cmd_o.op = bpa_pkg::OP_PUSH_LO;
        state_d  = bpa_pkg::S_A_PUSHHI;
      end
      bpa_pkg::S_A_PUSHHI: begin
        cmd_o.op = bpa_pkg::OP_PUSH_HI;
        state_d  = bpa_pkg::S_A_RDTOP;
      end
      bpa_pkg::S_F_CHECK: begin
        state_d = stat_i.cur_top ? bpa_pkg::S_F_PUSH : bpa_pkg::S_F_RDPAIR;
      end
      bpa_pkg::S_F_RDPAIR: begin
        cmd_o.op = bpa_pkg::OP_RD_PAIR;
        state_d  = bpa_pkg::S_F_DECIDE;
      end
      bpa_pkg::S_F_DECIDE: begin
        state_d = stat_i.pair_bit ? bpa_pkg::S_F_KINIT : bpa_pkg::S_F_PUSH;
      end
      bpa_pkg::S_F_KINIT: begin
        cmd_o.op = bpa_pkg::OP_K_INIT;
        state_d  = bpa_pkg::S_F_RDK;
      end
      bpa_pkg::S_F_RDK: begin
        if (stat_i.k_zero) begin
          res_d   = bpa_pkg::ST_BUDDY_MISSING;
          state_d = bpa_pkg::S_DONE;
        end else begin
          cmd_o.op = bpa_pkg::OP_RD_K;
          state_d  = bpa_pkg::S_F_CMP;
        end
      end
      bpa_pkg::S_F_CMP: begin
        state_d = stat_i.match ? bpa_pkg::S_F_MOVE : bpa_pkg::S_F_RDK;
      end
      bpa_pkg::S_F_MOVE: begin
        if (stat_i.move_more) begin
          cmd_o.op = bpa_pkg::OP_RD_NEXT;
          state_d  = bpa_pkg::S_F_WRMOVE;
        end else state_d = bpa_pkg::S_F_MERGE;
      end
      bpa_pkg::S_F_WRMOVE: begin
        cmd_o.op = bpa_pkg::OP_WR_MOVE;
        state_d  = bpa_pkg::S_F_MOVE;
      end
      bpa_pkg::S_F_MERGE: begin
        cmd_o.op = bpa_pkg::OP_MERGE;
        state_d  = bpa_pkg::S_F_CHECK;
      end
      bpa_pkg::S_F_PUSH: begin
        cmd_o.op = bpa_pkg::OP_PUSH_SET;
        state_d  = bpa_pkg::S_DONE;
      end
      bpa_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = bpa_pkg::S_IDLE;
        end
      end
      default: state_d = bpa_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/bpa_dp.sv -----
// datapath: free stacks, pair bitmap, stack counts and result register
module bpa_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpa_pkg::in_item_t   in_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output bpa_pkg::out_item_t  out_data_o,
  input  bpa_pkg::ctrl_cmd_t  cmd_i,
  output bpa_pkg::dp_stat_t   stat_o
);

  bpa_pkg::page_t stack_mem [bpa_pkg::STACK_DEPTH];
  logic           pair_mem  [bpa_pkg::PAIR_DEPTH];

  logic [bpa_pkg::CNT_W-1:0]   cnt_q [bpa_pkg::LEVELS];
  logic [bpa_pkg::CUR_W-1:0]   cur_q;
  logic [bpa_pkg::LVL_W-1:0]   req_q;
  bpa_pkg::page_t              page_q;
  logic [bpa_pkg::CNT_W-1:0]   k_q;
  logic [bpa_pkg::PADDR_W-1:0] clr_q;
  bpa_pkg::page_t              srd_q;
  logic                        prd_q;
  logic                        out_valid_q;
  bpa_pkg::out_item_t          out_q;

  logic [bpa_pkg::LVL_W-1:0]   cur_lv, lo_lv, up_lv;
  logic                        lv_ok;
  logic [bpa_pkg::CNT_W-1:0]   cnt_cur, cnt_lo;
  logic [bpa_pkg::SADDR_W-1:0] base_cur, base_lo;
  logic                        s_we, s_re, p_we, p_re, p_wdata;
  logic [bpa_pkg::SADDR_W-1:0] s_waddr, s_raddr;
  bpa_pkg::page_t              s_wdata;
  logic [bpa_pkg::PADDR_W-1:0] p_waddr, p_raddr;
  logic                        lo_room, cur_room;

  assign cur_lv   = cur_q[bpa_pkg::LVL_W-1:0];
  assign lo_lv    = cur_lv - bpa_pkg::LVL_W'(1);
  assign up_lv    = cur_lv + bpa_pkg::LVL_W'(1);
  assign lv_ok    = (cur_q < bpa_pkg::CUR_W'(bpa_pkg::LEVELS));
  assign cnt_cur  = lv_ok ? cnt_q[cur_lv] : '0;
  assign cnt_lo   = (lv_ok && cur_lv != '0) ? cnt_q[lo_lv] : '0;
  assign base_cur = bpa_pkg::stack_base(cur_lv);
  assign base_lo  = bpa_pkg::stack_base(lo_lv);
  assign lo_room  = (cnt_lo < bpa_pkg::stack_cap(lo_lv));
  assign cur_room = (cnt_cur < bpa_pkg::stack_cap(cur_lv));

  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = page_q;
    s_re    = 1'b0;
    s_raddr = '0;
    p_we    = 1'b0;
    p_waddr = bpa_pkg::pair_idx(cur_lv, page_q);
    p_wdata = 1'b0;
    p_re    = 1'b0;
    p_raddr = bpa_pkg::pair_idx(cur_lv, page_q);
    unique case (cmd_i.op)
      bpa_pkg::OP_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = clr_q;
      end
      bpa_pkg::OP_RD_TOP: begin
        s_re    = 1'b1;
        s_raddr = base_cur + bpa_pkg::SADDR_W'(cnt_cur) - bpa_pkg::SADDR_W'(1);
      end
      bpa_pkg::OP_RD_PAIR_TOP: begin
        p_re    = 1'b1;
        p_raddr = bpa_pkg::pair_idx(cur_lv, srd_q);
      end
      bpa_pkg::OP_TOGGLE: begin
        p_we    = 1'b1;
        p_wdata = ~prd_q;
      end
      bpa_pkg::OP_PUSH_LO: begin
        s_we    = lo_room;
        s_waddr = base_lo + bpa_pkg::SADDR_W'(cnt_lo);
      end
      bpa_pkg::OP_PUSH_HI: begin
        s_we    = lo_room;
        s_waddr = base_lo + bpa_pkg::SADDR_W'(cnt_lo);
        s_wdata = page_q + (bpa_pkg::PAGE_BITS'(1) << lo_lv);
      end
      bpa_pkg::OP_RD_PAIR: p_re = 1'b1;
      bpa_pkg::OP_RD_K: begin
        s_re    = 1'b1;
        s_raddr = base_cur + bpa_pkg::SADDR_W'(k_q) - bpa_pkg::SADDR_W'(1);
      end
      bpa_pkg::OP_RD_NEXT: begin
        s_re    = 1'b1;
        s_raddr = base_cur + bpa_pkg::SADDR_W'(k_q) + bpa_pkg::SADDR_W'(1);
      end
      bpa_pkg::OP_WR_MOVE: begin
        s_we    = 1'b1;
        s_waddr = base_cur + bpa_pkg::SADDR_W'(k_q);
        s_wdata = srd_q;
      end
      bpa_pkg::OP_MERGE: p_we = 1'b1;
      bpa_pkg::OP_PUSH_SET: begin
        s_we    = cur_room;
        s_waddr = base_cur + bpa_pkg::SADDR_W'(cnt_cur);
        p_we    = 1'b1;
        p_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_we) stack_mem[s_waddr] <= s_wdata;
    if (s_re) srd_q <= stack_mem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) pair_mem[p_waddr] <= p_wdata;
    if (p_re) prd_q <= pair_mem[p_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bpa_pkg::LEVELS; i++) cnt_q[i] <= '0;
      clr_q <= '0;
    end else begin
      unique case (cmd_i.op)
        bpa_pkg::OP_CLEAR:  clr_q <= clr_q + bpa_pkg::PADDR_W'(1);
        bpa_pkg::OP_TOGGLE, bpa_pkg::OP_MERGE:
          cnt_q[cur_lv] <= cnt_cur - bpa_pkg::CNT_W'(1);
        bpa_pkg::OP_PUSH_LO, bpa_pkg::OP_PUSH_HI: begin
          if (lo_room) cnt_q[lo_lv] <= cnt_lo + bpa_pkg::CNT_W'(1);
        end
        bpa_pkg::OP_PUSH_SET: begin
          if (cur_room) cnt_q[cur_lv] <= cnt_cur + bpa_pkg::CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      bpa_pkg::OP_LOAD: begin
        cur_q  <= {1'b0, in_data_i.level};
        req_q  <= in_data_i.level;
        page_q <= bpa_pkg::align(in_data_i.page, in_data_i.level);
      end
      bpa_pkg::OP_NEXT_LV:     cur_q  <= cur_q + bpa_pkg::CUR_W'(1);
      bpa_pkg::OP_RD_PAIR_TOP: page_q <= srd_q;
      bpa_pkg::OP_PUSH_HI:     cur_q  <= cur_q - bpa_pkg::CUR_W'(1);
      bpa_pkg::OP_K_INIT:      k_q    <= cnt_cur;
      bpa_pkg::OP_RD_K:        k_q    <= k_q - bpa_pkg::CNT_W'(1);
      bpa_pkg::OP_WR_MOVE:     k_q    <= k_q + bpa_pkg::CNT_W'(1);
      bpa_pkg::OP_MERGE: begin
        cur_q  <= cur_q + bpa_pkg::CUR_W'(1);
        page_q <= bpa_pkg::align(page_q, up_lv);
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.alloc_page <= cmd_i.res_page ? page_q : '0;
      out_q.status     <= cmd_i.res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.cur_ge    = ~lv_ok;
  assign stat_o.cur_top   = (cur_q == bpa_pkg::CUR_W'(bpa_pkg::LEVELS - 1));
  assign stat_o.cnt_zero  = (cnt_cur == '0);
  assign stat_o.at_req    = (cur_q == {1'b0, req_q});
  assign stat_o.pair_bit  = prd_q;
  assign stat_o.k_zero    = (k_q == '0);
  assign stat_o.match     = ((srd_q >> up_lv) == (page_q >> up_lv));
  assign stat_o.move_more = ({1'b0, k_q} + (bpa_pkg::CNT_W+1)'(1)) < {1'b0, cnt_cur};
  assign stat_o.out_free  = ~out_valid_q | ~out_stall_i;
  assign stat_o.clr_last  = (clr_q == '1);
  assign stat_o.req_bad   = ({1'b0, req_q} >= bpa_pkg::CUR_W'(bpa_pkg::LEVELS));

endmodule
